// File: sv/udwt_pkg.sv
// ----------------------------------------------------------------------------
// udwt_pkg
// Types, constants and the column width table shared by the truncator.
// ----------------------------------------------------------------------------
`default_nettype none

package udwt_pkg;

	localparam int CP_W   = 21;
	localparam int LEN_W  = 3;
	localparam int COL_W  = 2;
	localparam int RUN_W  = 16;
	localparam int LIM_W  = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_LIMIT     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TRUNCATE_ENABLE = 2'd1;

	localparam logic [LIM_W-1:0] WIDTH_LIMIT_RST = 16'd48;

	localparam logic [CP_W-1:0] CP_MAX      = 21'h10FFFF;
	localparam logic [CP_W-1:0] SURR_LO     = 21'h00D800;
	localparam logic [CP_W-1:0] SURR_HI     = 21'h00DFFF;
	localparam logic [CP_W-1:0] MIN_TWO     = 21'h000080;
	localparam logic [CP_W-1:0] MIN_THREE   = 21'h000800;
	localparam logic [CP_W-1:0] MIN_FOUR    = 21'h010000;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;   // take the input byte into the byte buffer
		logic parse;  // decode the front of the buffer and shift it
		logic emit;   // account the decoded code point and fill the output
	} udwt_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_more;  // front sequence is incomplete and text not ended
		logic empty;      // byte buffer holds nothing
		logic out_free;   // output register can take a result this cycle
	} udwt_status_t;

	function automatic logic in_rng(input logic [CP_W-1:0] c,
	                                input logic [CP_W-1:0] lo,
	                                input logic [CP_W-1:0] hi);
		return (c >= lo) && (c <= hi);
	endfunction

	// Terminal column width of one code point.
	function automatic logic [COL_W-1:0] column_width_of(input logic [CP_W-1:0] c);
		logic zero_w;
		logic wide_w;
		zero_w = (c < 21'h20) || in_rng(c, 21'h7F, 21'h9F) ||
			in_rng(c, 21'h0300, 21'h036F) || in_rng(c, 21'h1AB0, 21'h1AFF) ||
			in_rng(c, 21'h1DC0, 21'h1DFF) || in_rng(c, 21'h200B, 21'h200F) ||
			in_rng(c, 21'h20D0, 21'h20FF) || in_rng(c, 21'hFE00, 21'hFE0F) ||
			in_rng(c, 21'hFE20, 21'hFE2F) || (c == 21'h2060) || (c == 21'hFEFF);
		wide_w = in_rng(c, 21'h1100, 21'h115F) || in_rng(c, 21'h2E80, 21'hA4CF) ||
			in_rng(c, 21'hA960, 21'hA97F) || in_rng(c, 21'hAC00, 21'hD7A3) ||
			in_rng(c, 21'hF900, 21'hFAFF) || in_rng(c, 21'hFE10, 21'hFE19) ||
			in_rng(c, 21'hFE30, 21'hFE6F) || in_rng(c, 21'hFF00, 21'hFF60) ||
			in_rng(c, 21'hFFE0, 21'hFFE6) || in_rng(c, 21'h1F300, 21'h1F64F) ||
			in_rng(c, 21'h1F900, 21'h1F9FF) || in_rng(c, 21'h20000, 21'h3FFFD);
		if (zero_w) begin
			return 2'd0;
		end else if (wide_w) begin
			return 2'd2;
		end
		return 2'd1;
	endfunction

endpackage

`default_nettype wire

// File: sv/udwt_ctrl.sv
// ----------------------------------------------------------------------------
// udwt_ctrl
// Sequencer: accepts a byte, then alternates decode and emit until the
// buffer is empty or holds only the start of an unfinished sequence.
// ----------------------------------------------------------------------------
`default_nettype none

module udwt_ctrl import udwt_pkg::*; (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          in_valid,
	output logic         in_stall,
	input  udwt_status_t status,
	output udwt_cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_PARSE = 2'd1;
	localparam logic [1:0] ST_EMIT  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nx;

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = ST_PARSE;
				end
			end
			ST_PARSE: begin
				if (status.need_more) begin
					state_nx = ST_IDLE;
				end else begin
					cmd.parse = 1'b1;
					state_nx  = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_nx = status.empty ? ST_IDLE : ST_PARSE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

`default_nettype wire

// File: sv/udwt_dp.sv
// ----------------------------------------------------------------------------
// udwt_dp
// Byte buffer, UTF-8 front decoder, width accounting, configuration
// registers and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module udwt_dp import udwt_pkg::*; #(
	parameter int WIDTH_BITS = 16
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  udwt_cmd_t            cmd,
	output udwt_status_t         status,
	input  wire  [7:0]           text_byte,
	input  wire                  end_of_text,
	input  wire                  cfg_valid,
	input  wire  [CFG_IDX_W-1:0] cfg_index,
	input  wire  [LIM_W-1:0]     cfg_data,
	output logic                 out_valid,
	input  wire                  out_stall,
	output logic [CP_W-1:0]      code_point,
	output logic [LEN_W-1:0]     byte_length,
	output logic [COL_W-1:0]     column_width,
	output logic [RUN_W-1:0]     running_width,
	output logic                 keep_mark,
	output logic                 over_limit,
	output logic                 text_done
);

	// Compare width: holds a total plus one width, and at least a 16-bit value plus one.
	localparam int CW = (WIDTH_BITS + 1 > LIM_W + 1) ? WIDTH_BITS + 1 : LIM_W + 1;

	logic [7:0]            byte_q [4];
	logic [2:0]            count_q;
	logic                  eot_q;
	logic [CP_W-1:0]       cp_s1;
	logic [LEN_W-1:0]      len_s1;
	logic [WIDTH_BITS-1:0] total_q;
	logic                  exceeded_q;
	logic [LIM_W-1:0]      limit_q;
	logic                  trunc_q;
	logic                  out_valid_q;

	// ---------------- front decoder ----------------
	logic [7:0]       lead;
	logic [2:0]       need;
	logic             bad_lead;
	logic             bad_cont;
	logic             short_seq;
	logic [CP_W-1:0]  v2, v3, v4;
	logic             bad_val;
	logic             need_more;
	logic [CP_W-1:0]  dec_cp;
	logic [LEN_W-1:0] dec_len;

	always_comb begin
		lead     = byte_q[0];
		bad_lead = 1'b0;
		need     = 3'd1;
		if (lead[7] == 1'b0) begin
			need = 3'd1;
		end else if (lead[7:5] == 3'b110) begin
			need = 3'd2;
		end else if (lead[7:4] == 4'b1110) begin
			need = 3'd3;
		end else if (lead[7:3] == 5'b11110) begin
			need = 3'd4;
		end else begin
			bad_lead = 1'b1;
		end

		// Only bytes that are present and belong to the sequence are checked.
		bad_cont = ((count_q > 3'd1) && (need > 3'd1) && (byte_q[1][7:6] != 2'b10)) ||
			((count_q > 3'd2) && (need > 3'd2) && (byte_q[2][7:6] != 2'b10)) ||
			((count_q > 3'd3) && (need > 3'd3) && (byte_q[3][7:6] != 2'b10));
		short_seq = count_q < need;

		v2 = {10'd0, lead[4:0], byte_q[1][5:0]};
		v3 = {5'd0, lead[3:0], byte_q[1][5:0], byte_q[2][5:0]};
		v4 = {lead[2:0], byte_q[1][5:0], byte_q[2][5:0], byte_q[3][5:0]};
		case (need)
			3'd2:    bad_val = v2 < MIN_TWO;
			3'd3:    bad_val = (v3 < MIN_THREE) || ((v3 >= SURR_LO) && (v3 <= SURR_HI));
			3'd4:    bad_val = (v4 < MIN_FOUR) || (v4 > CP_MAX);
			default: bad_val = 1'b0;
		endcase

		need_more = !bad_lead && !bad_cont && short_seq && !eot_q;

		dec_cp  = {13'd0, lead};
		dec_len = 3'd1;
		if (!bad_lead && !bad_cont && !short_seq && !bad_val) begin
			dec_len = need;
			case (need)
				3'd2:    dec_cp = v2;
				3'd3:    dec_cp = v3;
				3'd4:    dec_cp = v4;
				default: dec_cp = {13'd0, lead};
			endcase
		end
	end

	assign status.need_more = need_more;
	assign status.empty     = (count_q == 3'd0);
	assign status.out_free  = !out_valid_q || !out_stall;

	// ---------------- byte buffer ----------------
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			byte_q[count_q[1:0]] <= text_byte;
		end else if (cmd.parse) begin
			case (dec_len)
				3'd1: begin
					byte_q[0] <= byte_q[1];
					byte_q[1] <= byte_q[2];
					byte_q[2] <= byte_q[3];
				end
				3'd2: begin
					byte_q[0] <= byte_q[2];
					byte_q[1] <= byte_q[3];
				end
				3'd3: begin
					byte_q[0] <= byte_q[3];
				end
				default: begin
				end
			endcase
		end
		if (cmd.parse) begin
			cp_s1  <= dec_cp;
			len_s1 <= dec_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 3'd0;
			eot_q   <= 1'b0;
		end else if (cmd.load) begin
			count_q <= count_q + 3'd1;
			eot_q   <= end_of_text;
		end else if (cmd.parse) begin
			count_q <= count_q - dec_len;
		end
	end

	// ---------------- width accounting ----------------
	logic [COL_W-1:0]      col_w;
	logic [CW-1:0]         next_sum;
	logic [CW-1:0]         limit_ext;
	logic [WIDTH_BITS-1:0] total_nx;
	logic [CW-1:0]         total_ext;
	logic                  no_fit;
	logic                  keep_nx;
	logic                  last_res;

	always_comb begin
		col_w     = column_width_of(cp_s1);
		next_sum  = CW'(total_q) + CW'(col_w);
		limit_ext = CW'(limit_q);
		total_nx  = (next_sum > CW'({WIDTH_BITS{1'b1}})) ? {WIDTH_BITS{1'b1}}
			: next_sum[WIDTH_BITS-1:0];
		total_ext = CW'(total_nx);
		// With a limit of two or more, exceeding limit minus one means reaching the limit.
		no_fit    = exceeded_q || (limit_q <= 16'd1) || (next_sum >= limit_ext);
		keep_nx   = !trunc_q || !no_fit;
		last_res  = eot_q && (count_q == 3'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q    <= '0;
			exceeded_q <= 1'b0;
		end else if (cmd.emit) begin
			if (last_res) begin
				total_q    <= '0;
				exceeded_q <= 1'b0;
			end else begin
				total_q    <= total_nx;
				exceeded_q <= exceeded_q || (trunc_q && no_fit);
			end
		end
	end

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= WIDTH_LIMIT_RST;
			trunc_q <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_WIDTH_LIMIT:     limit_q <= cfg_data;
				CFG_TRUNCATE_ENABLE: trunc_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			code_point    <= cp_s1;
			byte_length   <= len_s1;
			column_width  <= col_w;
			running_width <= (total_ext > CW'(16'hFFFF)) ? 16'hFFFF : total_ext[RUN_W-1:0];
			keep_mark     <= keep_nx;
			over_limit    <= total_ext > limit_ext;
			text_done     <= last_res;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// File: sv/utf8_display_width_truncator.sv
// ----------------------------------------------------------------------------
// utf8_display_width_truncator
// UTF-8 decoder with terminal column widths, running total and keep marks.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_stall    text_byte, end_of_text
//   out      source     out_valid / out_stall  code_point .. text_done
//   cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A byte is taken in the idle state, then each result passes through a decode
// step on the front of the byte buffer and an emit step that accounts its width
// into the output register. A byte that only extends a sequence goes back to
// idle with no result. A stalled output register holds the emit step only.
// Reset clears the controller, counts and totals; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_display_width_truncator import udwt_pkg::*; #(
	parameter int WIDTH_BITS = 16
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_stall,
	input  wire  [7:0]           text_byte,
	input  wire                  end_of_text,
	output logic                 out_valid,
	input  wire                  out_stall,
	output logic [CP_W-1:0]      code_point,
	output logic [LEN_W-1:0]     byte_length,
	output logic [COL_W-1:0]     column_width,
	output logic [RUN_W-1:0]     running_width,
	output logic                 keep_mark,
	output logic                 over_limit,
	output logic                 text_done,
	input  wire                  cfg_valid,
	output logic                 cfg_ready,
	input  wire  [CFG_IDX_W-1:0] cfg_index,
	input  wire  [LIM_W-1:0]     cfg_data
);

	udwt_cmd_t    cmd;
	udwt_status_t status;

	assign cfg_ready = 1'b1;

	udwt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	udwt_dp #(
		.WIDTH_BITS (WIDTH_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.text_byte     (text_byte),
		.end_of_text   (end_of_text),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.code_point    (code_point),
		.byte_length   (byte_length),
		.column_width  (column_width),
		.running_width (running_width),
		.keep_mark     (keep_mark),
		.over_limit    (over_limit),
		.text_done     (text_done)
	);

endmodule

`default_nettype wire

// File: sv/udwt_checker.sv
// ----------------------------------------------------------------------------
// udwt_checker
// Port-level checks of the truncator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module udwt_checker import udwt_pkg::*; (
	input wire                  clk,
	input wire                  arst_n,
	input wire                  out_valid,
	input wire                  out_stall,
	input wire [CP_W-1:0]       code_point,
	input wire [LEN_W-1:0]      byte_length,
	input wire [COL_W-1:0]      column_width,
	input wire                  text_done
);

	// A result waiting on a stalled consumer stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out_valid dropped while stalled");

	// A stalled result keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(code_point) && $stable(text_done))
		else $error("payload changed while stalled");

	// Every result consumes one to four bytes and is at most two columns wide.
	a_len_width: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> byte_length >= 3'd1 && byte_length <= 3'd4 && column_width <= 2'd2)
		else $error("byte_length or column_width out of range");

	// A multi-byte result is a real, non-ASCII code point within range.
	a_multi_cp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_length != 3'd1 |-> code_point >= MIN_TWO && code_point <= CP_MAX)
		else $error("multi-byte code point out of range");

endmodule

bind utf8_display_width_truncator udwt_checker u_udwt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.code_point   (code_point),
	.byte_length  (byte_length),
	.column_width (column_width),
	.text_done    (text_done)
);

`default_nettype wire

// File: tb/glyph_width_checker.sv
// ----------------------------------------------------------------------------
// glyph_width_checker
// Watches the byte, result and register channels of the UTF-8 width
// truncator. It decodes each accepted byte on its own, queues the code
// points it expects and compares every result transfer field by field.
// ----------------------------------------------------------------------------

module glyph_width_checker import udwt_pkg::*; #(
	parameter int WIDTH_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic [7:0]           text_byte,
	input  logic                 end_of_text,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic [CP_W-1:0]      code_point,
	input  logic [LEN_W-1:0]     byte_length,
	input  logic [COL_W-1:0]     column_width,
	input  logic [RUN_W-1:0]     running_width,
	input  logic                 keep_mark,
	input  logic                 over_limit,
	input  logic                 text_done,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [LIM_W-1:0]     cfg_data,
	output int                   mismatches,
	output int                   outstanding
);

	localparam longint unsigned TOTAL_MAX = (64'd1 << WIDTH_BITS) - 64'd1;

	typedef struct packed {
		logic [CP_W-1:0]  cp;
		logic [LEN_W-1:0] len;
		logic [COL_W-1:0] cols;
		logic [RUN_W-1:0] run;
		logic             keep;
		logic             over;
		logic             done;
	} glyph_t;

	// Decoder state: bytes of an unfinished sequence and the text totals.
	logic [7:0]        held [0:2];
	int unsigned       held_n;
	longint unsigned   cols_total;
	bit                budget_spent;
	logic [LIM_W-1:0]  limit;
	bit                trunc_on;
	glyph_t            glyphs_due [$];

	task automatic report(input string what);
		mismatches++;
		$display("[%0t] mismatch: %s", $time, what);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want) begin
			report($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
		end
	endtask

	function automatic bit spans(input logic [CP_W-1:0] c, input int unsigned lo,
		input int unsigned hi);
		return (c >= lo) && (c <= hi);
	endfunction

	function automatic logic [1:0] columns_of(input logic [CP_W-1:0] c);
		if (c < 'h20 || spans(c, 'h7F, 'h9F)) begin
			return 2'd0;
		end
		if (spans(c, 'h0300, 'h036F) || spans(c, 'h1AB0, 'h1AFF) ||
			spans(c, 'h1DC0, 'h1DFF) || spans(c, 'h200B, 'h200F) ||
			spans(c, 'h20D0, 'h20FF) || spans(c, 'hFE00, 'hFE0F) ||
			spans(c, 'hFE20, 'hFE2F) || c == 'h2060 || c == 'hFEFF) begin
			return 2'd0;
		end
		if (spans(c, 'h1100, 'h115F) || spans(c, 'h2E80, 'hA4CF) ||
			spans(c, 'hA960, 'hA97F) || spans(c, 'hAC00, 'hD7A3) ||
			spans(c, 'hF900, 'hFAFF) || spans(c, 'hFE10, 'hFE19) ||
			spans(c, 'hFE30, 'hFE6F) || spans(c, 'hFF00, 'hFF60) ||
			spans(c, 'hFFE0, 'hFFE6) || spans(c, 'h1F300, 'h1F64F) ||
			spans(c, 'h1F900, 'h1F9FF) || spans(c, 'h20000, 'h3FFFD)) begin
			return 2'd2;
		end
		return 2'd1;
	endfunction

	// Decodes the front of seq (n bytes, first byte in the low bits). Returns the
	// bytes taken, or 0 while a sequence that may still be valid is incomplete.
	function automatic int unsigned decode_front(input logic [31:0] seq,
		input int unsigned n, input bit eot, output logic [CP_W-1:0] cp);
		logic [7:0]  lead;
		int unsigned need;
		int unsigned v;
		int unsigned i;
		lead = seq[7:0];
		cp = {13'd0, lead};
		if (!lead[7]) begin
			return 1;
		end
		if (lead[7:5] == 3'b110) begin
			need = 2;
		end else if (lead[7:4] == 4'b1110) begin
			need = 3;
		end else if (lead[7:3] == 5'b11110) begin
			need = 4;
		end else begin
			return 1;
		end
		for (i = 1; i < n && i < need; i++) begin
			if (seq[8*i+6 +: 2] != 2'b10) begin
				return 1;
			end
		end
		if (n < need) begin
			return eot ? 1 : 0;
		end
		case (need)
			2: begin
				v = 32'({lead[4:0], seq[13:8]});
				if (v < 'h80) begin
					return 1;
				end
			end
			3: begin
				v = 32'({lead[3:0], seq[13:8], seq[21:16]});
				if (v < 'h800 || (v >= 'hD800 && v <= 'hDFFF)) begin
					return 1;
				end
			end
			default: begin
				v = 32'({lead[2:0], seq[13:8], seq[21:16], seq[29:24]});
				if (v < 'h10000 || v > 'h10FFFF) begin
					return 1;
				end
			end
		endcase
		cp = v[CP_W-1:0];
		return need;
	endfunction

	// Adds one code point to the text totals and builds its result.
	function automatic glyph_t tally_columns(input logic [CP_W-1:0] cp,
		input int unsigned len);
		glyph_t          g;
		logic [1:0]      w;
		longint unsigned nxt;
		w = columns_of(cp);
		nxt = cols_total + w;
		if (!trunc_on) begin
			g.keep = 1'b1;
		end else if (budget_spent || limit <= 1 || nxt > limit - 1) begin
			// Once one code point overflows the budget, nothing later is kept.
			g.keep = 1'b0;
			budget_spent = 1'b1;
		end else begin
			g.keep = 1'b1;
		end
		cols_total = (nxt > TOTAL_MAX) ? TOTAL_MAX : nxt;
		g.cp = cp;
		g.len = len[LEN_W-1:0];
		g.cols = w;
		g.run = (cols_total > 'hFFFF) ? 16'hFFFF : cols_total[RUN_W-1:0];
		g.over = cols_total > limit;
		g.done = 1'b0;
		return g;
	endfunction

	task automatic decode_byte(input logic [7:0] nb, input bit eot);
		logic [31:0]     seq;
		int unsigned     n;
		int unsigned     used;
		int unsigned     i;
		logic [CP_W-1:0] cp;
		glyph_t          batch [$];
		seq = '0;
		for (i = 0; i < held_n; i++) begin
			seq[8*i +: 8] = held[i];
		end
		seq[8*held_n +: 8] = nb;
		n = held_n + 1;
		while (n > 0 && batch.size() < 4) begin
			used = decode_front(seq, n, eot, cp);
			if (used == 0) begin
				break;
			end
			batch.insert(batch.size(), tally_columns(cp, used));
			// Rejected lead bytes take one byte; the rest is parsed again.
			seq = seq >> (8 * used);
			n -= used;
		end
		if (eot) begin
			if (batch.size() > 0) begin
				batch[batch.size() - 1].done = 1'b1;
			end
			held_n = 0;
			cols_total = 0;
			budget_spent = 1'b0;
		end else begin
			if (n > 3) begin
				n = 3;
			end
			for (i = 0; i < n; i++) begin
				held[i] = seq[8*i +: 8];
			end
			held_n = n;
		end
		glyphs_due = {glyphs_due, batch};
	endtask

	always @(posedge clk) begin
		glyph_t want;
		if (!arst_n) begin
			held_n = 0;
			cols_total = 0;
			budget_spent = 1'b0;
			limit = WIDTH_LIMIT_RST;
			trunc_on = 1'b1;
			glyphs_due.delete();
		end else begin
			// Results are compared before this edge's byte is decoded, so a
			// result can never be matched against its own input.
			if (out_valid && !out_stall) begin
				if (glyphs_due.size() == 0) begin
					report($sformatf("unexpected result transfer, code point 0x%0h",
						code_point));
				end else begin
					want = glyphs_due.pop_front();
					check_field("code_point", 32'(code_point), 32'(want.cp));
					check_field("byte_length", 32'(byte_length), 32'(want.len));
					check_field("column_width", 32'(column_width), 32'(want.cols));
					check_field("running_width", 32'(running_width), 32'(want.run));
					check_field("keep_mark", 32'(keep_mark), 32'(want.keep));
					check_field("over_limit", 32'(over_limit), 32'(want.over));
					check_field("text_done", 32'(text_done), 32'(want.done));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_WIDTH_LIMIT:     limit = cfg_data;
					CFG_TRUNCATE_ENABLE: trunc_on = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				decode_byte(text_byte, end_of_text);
			end
		end
		outstanding = glyphs_due.size();
	end

endmodule

// File: tb/utf8_display_width_truncator_test.sv
// ----------------------------------------------------------------------------
// utf8_display_width_truncator_test
// Feeds texts of valid and malformed UTF-8 through the truncator under a
// series of limit and truncation settings, with bursty input and a stalling
// receiver. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------

module utf8_display_width_truncator_test import udwt_pkg::*; ();

	localparam int WIDTH_BITS      = 16;
	localparam int RESET_CYCLES    = 5;
	localparam int SETTLE_CYCLES   = 12;
	localparam int LONG_HOLD       = 300;
	localparam int CYCLE_LIMIT     = 200_000;
	localparam int LONG_TEXT_BYTES = 40;

	// Indexes past the register list; writes to them must be ignored.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HALF, STALL_HEAVY} stall_mode_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [7:0]           text_byte;
	logic                 end_of_text;
	logic                 out_valid;
	logic                 out_stall;
	logic [CP_W-1:0]      code_point;
	logic [LEN_W-1:0]     byte_length;
	logic [COL_W-1:0]     column_width;
	logic [RUN_W-1:0]     running_width;
	logic                 keep_mark;
	logic                 over_limit;
	logic                 text_done;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [LIM_W-1:0]     cfg_data;

	int          mismatches;
	int          outstanding;
	int          hold_requests;
	bit          steady;
	bit          rx_fast;
	int unsigned bytes_sent;
	int unsigned burst_left;
	int unsigned gap_due;
	logic [7:0]  text_q [$];

	utf8_display_width_truncator #(
		.WIDTH_BITS(WIDTH_BITS)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.text_byte    (text_byte),
		.end_of_text  (end_of_text),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.code_point   (code_point),
		.byte_length  (byte_length),
		.column_width (column_width),
		.running_width(running_width),
		.keep_mark    (keep_mark),
		.over_limit   (over_limit),
		.text_done    (text_done),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	glyph_width_checker #(
		.WIDTH_BITS(WIDTH_BITS)
	) i_glyph_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.text_byte    (text_byte),
		.end_of_text  (end_of_text),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.code_point   (code_point),
		.byte_length  (byte_length),
		.column_width (column_width),
		.running_width(running_width),
		.keep_mark    (keep_mark),
		.over_limit   (over_limit),
		.text_done    (text_done),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	// Receiver: stall patterns in segments of random length, plus a long
	// hold-off whenever one is requested.
	initial begin
		stall_mode_t mode;
		int          seg_left;
		int          hold_left;
		int          holds_served;
		mode = STALL_NONE;
		seg_left = 0;
		hold_left = 0;
		holds_served = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (holds_served != hold_requests) begin
				holds_served = hold_requests;
				hold_left = LONG_HOLD;
				out_stall <= 1'b1;
			end else begin
				if (seg_left == 0) begin
					seg_left = $urandom_range(4, 60);
					mode = rx_fast ? STALL_NONE : stall_mode_t'($urandom_range(0, 3));
				end
				seg_left--;
				case (mode)
					STALL_NONE:  out_stall <= 1'b0;
					STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
					STALL_HALF:  out_stall <= ($urandom_range(0, 1) != 0);
					default:     out_stall <= ($urandom_range(0, 4) != 0);
				endcase
			end
		end
	end

	task automatic offer(input logic [7:0] b, input bit last);
		if (gap_due > 0) begin
			in_valid <= 1'b0;
			repeat (gap_due) @(posedge clk);
			gap_due = 0;
		end
		in_valid <= 1'b1;
		text_byte <= b;
		end_of_text <= last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		bytes_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (!steady) begin
				gap_due = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
					: $urandom_range(0, 4);
			end
		end
	endtask

	task automatic send_queued();
		int i;
		for (i = 0; i < text_q.size(); i++) begin
			offer(text_q[i], i == text_q.size() - 1);
		end
		text_q.delete();
	endtask

	// Stops offering and waits until every expected result has been taken.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
		input logic [LIM_W-1:0] data, input bit last);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (last) begin
			cfg_valid <= 1'b0;
		end
	endtask

	task automatic configure(input logic [LIM_W-1:0] limit, input bit enable,
		input bit spares);
		logic [LIM_W-2:0] junk;
		junk = 15'($urandom);
		if (spares) begin
			cfg_write(CFG_SPARE_A, LIM_W'($urandom), 1'b0);
			cfg_write(CFG_SPARE_B, LIM_W'($urandom), 1'b0);
		end
		cfg_write(CFG_WIDTH_LIMIT, limit, 1'b0);
		// Only bit 0 of the enable register counts; the rest is noise.
		cfg_write(CFG_TRUNCATE_ENABLE, {junk, enable}, 1'b1);
	endtask

	function automatic int unsigned table_boundary(input int k);
		case (k)
			0:  return 'h20;
			1:  return 'h7F;
			2:  return 'hA0;
			3:  return 'h300;
			4:  return 'h370;
			5:  return 'h1100;
			6:  return 'h1160;
			7:  return 'h1AB0;
			8:  return 'h1B00;
			9:  return 'h1DC0;
			10: return 'h1E00;
			11: return 'h200B;
			12: return 'h2010;
			13: return 'h20D0;
			14: return 'h2100;
			15: return 'h2061;
			16: return 'h2E80;
			17: return 'hA4D0;
			18: return 'hA960;
			19: return 'hA980;
			20: return 'hAC00;
			21: return 'hD7A4;
			22: return 'hF900;
			23: return 'hFB00;
			24: return 'hFE00;
			25: return 'hFE10;
			26: return 'hFE1A;
			27: return 'hFE20;
			28: return 'hFE30;
			29: return 'hFE70;
			30: return 'hFF00;
			31: return 'hFF61;
			32: return 'hFFE0;
			33: return 'hFFE7;
			34: return 'h1F300;
			35: return 'h1F650;
			36: return 'h1F900;
			37: return 'h1FA00;
			38: return 'h20000;
			39: return 'h3FFFE;
			40: return 'h80;
			41: return 'h800;
			42: return 'h10000;
			default: return 'h110000;
		endcase
	endfunction

	function automatic logic [CP_W-1:0] pick_code_point();
		int unsigned c;
		case ($urandom_range(0, 9))
			0, 1, 2: c = $urandom_range(0, 'h7F);
			3:       c = $urandom_range('h80, 'h7FF);
			4:       c = ($urandom_range(0, 1) != 0) ? $urandom_range('h4E00, 'h9FFF)
				: $urandom_range('hAC00, 'hD7A3);
			5: begin
				c = $urandom_range('h800, 'hFFFF);
				if (c >= 'hD800 && c <= 'hDFFF) begin
					c -= 'h800;
				end
			end
			6:       c = $urandom_range('h10000, 'h10FFFF);
			7:       c = ($urandom_range(0, 1) != 0) ? $urandom_range('h1F300, 'h1F64F)
				: $urandom_range('h300, 'h36F);
			default: c = table_boundary($urandom_range(0, 43)) - $urandom_range(0, 1);
		endcase
		if (c > 'h10FFFF) begin
			c = 'h10FFFF;
		end
		return c[CP_W-1:0];
	endfunction

	function automatic void add_byte(input logic [7:0] b);
		text_q.insert(text_q.size(), b);
	endfunction

	function automatic void add_utf8(input logic [CP_W-1:0] c);
		if (c < 'h80) begin
			add_byte(c[7:0]);
		end else if (c < 'h800) begin
			add_byte({3'b110, c[10:6]});
			add_byte({2'b10, c[5:0]});
		end else if (c < 'h10000) begin
			add_byte({4'b1110, c[15:12]});
			add_byte({2'b10, c[11:6]});
			add_byte({2'b10, c[5:0]});
		end else begin
			add_byte({5'b11110, c[20:18]});
			add_byte({2'b10, c[17:12]});
			add_byte({2'b10, c[11:6]});
			add_byte({2'b10, c[5:0]});
		end
	endfunction

	function automatic logic [7:0] tail_byte();
		logic [5:0] bits;
		bits = 6'($urandom);
		return {2'b10, bits};
	endfunction

	function automatic void add_malformed();
		logic [7:0] b;
		b = 8'($urandom);
		case ($urandom_range(0, 6))
			0: add_byte(tail_byte());
			1: add_byte(8'($urandom_range('hF8, 'hFF)));
			2: begin
				// Lead byte with too few continuation bytes.
				add_byte({4'b1110, b[3:0]});
				add_byte(tail_byte());
			end
			3: begin
				case ($urandom_range(0, 2))
					0: add_byte({7'b1100000, b[0]});
					1: begin
						add_byte(8'hE0);
						add_byte(8'($urandom_range('h80, 'h9F)));
					end
					default: begin
						add_byte(8'hF0);
						add_byte(8'($urandom_range('h80, 'h8F)));
						add_byte(tail_byte());
					end
				endcase
				add_byte(tail_byte());
			end
			4: begin
				add_byte(8'hED);
				add_byte(8'($urandom_range('hA0, 'hBF)));
				add_byte(tail_byte());
			end
			5: begin
				if (b[0]) begin
					add_byte(8'hF4);
					add_byte(8'($urandom_range('h90, 'hBF)));
				end else begin
					add_byte(8'($urandom_range('hF5, 'hF7)));
					add_byte(tail_byte());
				end
				add_byte(tail_byte());
				add_byte(tail_byte());
			end
			default: add_byte(b);
		endcase
	endfunction

	task automatic run_phase(input int unsigned byte_goal);
		int unsigned start;
		int unsigned n_cps;
		int          i;
		start = bytes_sent;
		while (bytes_sent - start < byte_goal) begin
			n_cps = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 40)
				: $urandom_range(1, 8);
			for (i = 0; i < n_cps; i++) begin
				if ($urandom_range(0, 99) < 15) begin
					add_malformed();
				end else begin
					add_utf8(pick_code_point());
				end
			end
			send_queued();
		end
	endtask

	initial begin
		int i;
		arst_n = 1'b0;
		in_valid = 1'b0;
		text_byte = 8'h00;
		end_of_text = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_WIDTH_LIMIT;
		cfg_data = '0;
		hold_requests = 0;
		steady = 1'b0;
		rx_fast = 1'b0;
		bytes_sent = 0;
		burst_left = 0;
		gap_due = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed texts under the reset settings: control and impossible
		// bytes, a combining mark, an overlong pair, a wide character, a
		// surrogate, an emoji, a value above the code space, a cut sequence
		// that yields four results at once, and a text cut short at its end.
		text_q = '{8'h00, 8'hFF, 8'hCC, 8'h81, 8'hC0, 8'h80, 8'hE4, 8'hB8, 8'hAD,
			8'hED, 8'hA0, 8'h80};
		send_queued();
		text_q = '{8'hF0, 8'h9F, 8'h98, 8'h80, 8'hF4, 8'h90, 8'h80, 8'h80,
			8'hF0, 8'h9F, 8'h98, 8'h41};
		send_queued();
		text_q = '{8'hE4, 8'hB8};
		send_queued();
		drain();

		// Tiny limits (nothing may be kept below two), then the largest limit with truncation off and on.
		configure(16'd0, 1'b1, 1'b0);
		run_phase(25);
		drain();
		configure(16'd1, 1'b1, 1'b0);
		run_phase(20);
		drain();
		configure(16'd2, 1'b1, 1'b1);
		run_phase(20);
		drain();
		configure(16'hFFFF, 1'b0, 1'b0);
		run_phase(25);
		drain();
		configure(16'hFFFF, 1'b1, 1'b0);
		run_phase(25);
		drain();

		// The sender pauses mid-phase until every result is out.
		configure(LIM_W'($urandom_range(3, 60)), 1'b1, 1'b0);
		run_phase(15);
		drain();
		run_phase(15);
		drain();

		// Long receiver hold-off while bytes keep coming, so the input stalls.
		configure(16'd48, 1'b1, 1'b0);
		steady = 1'b1;
		hold_requests++;
		run_phase(40);
		steady = 1'b0;
		drain();

		configure(LIM_W'($urandom_range(0, 16'hFFFF)), ($urandom_range(0, 1) != 0), 1'b1);
		run_phase(25);
		drain();
		configure(LIM_W'($urandom_range(5, 30)), 1'b0, 1'b0);
		run_phase(25);
		drain();
		configure(16'd10, 1'b1, 1'b0);
		run_phase(25);
		drain();

		// One long text of single-column bytes runs well past a small limit.
		configure(16'd20, 1'b1, 1'b0);
		steady = 1'b1;
		rx_fast = 1'b1;
		for (i = 0; i < LONG_TEXT_BYTES; i++) begin
			offer(8'($urandom_range('h20, 'h7E)), i == LONG_TEXT_BYTES - 1);
		end
		steady = 1'b0;
		rx_fast = 1'b0;
		drain();

		if (mismatches == 0 && outstanding == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// File: filelist.f
sv/udwt_pkg.sv
sv/udwt_ctrl.sv
sv/udwt_dp.sv
sv/utf8_display_width_truncator.sv
sv/udwt_checker.sv
tb/glyph_width_checker.sv
tb/utf8_display_width_truncator_test.sv
